>>> sv/cqrw_pkg.sv
// Shared widths and defaults for the circle quadrant row width generator.
// No dependencies; used by every module of the block.
package cqrw_pkg;

    localparam int RADIUS_W           = 6;   // radius field width
    localparam int ROW_W              = 6;   // row width field and stack entry width
    localparam int DEC_W              = 12;  // signed midpoint decision variable
    localparam int MAX_RADIUS_DEFAULT = 63;

endpackage

>>> sv/cqrw_stack.sv
// Step stack storage: single write port, one registered read port.
// Depends on cqrw_pkg for the default entry width.
module cqrw_stack #(
    parameter int AW = 6,
    parameter int DW = cqrw_pkg::ROW_W
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/circle_quadrant_row_widths_top.sv
// Circle quadrant row width generator, top level.
// Depends on cqrw_pkg and instantiates cqrw_stack.
//
// Usage:
//   Input channel (s_valid/s_ready/s_radius): one transaction carries a radius.
//   Output channel (m_valid/m_ready/m_row_width/m_last_row): one transaction
//   per quadrant row, rows in order from the axis outward; m_last_row marks
//   the final row of the radius. A radius of zero produces no rows.
//   Radii above MAX_RADIUS are clamped to MAX_RADIUS.
//
// Sequencing:
//   An accepted radius moves the sequencer from ST_IDLE to ST_SCAN, which
//   loads each scan row into the output register. A radius r yields about r
//   rows; each midpoint pass goes through the decision adder and each x step
//   pushes a row onto the stack. ST_PREP primes the registered stack read
//   between scan and unstack, and ST_POP then pops the stacked rows.
//   s_ready is high only while the sequencer is idle; a new radius is taken
//   while the final row may still sit in the output register.
//
// Stalls and reset:
//   When m_ready is low the output register holds its row and the sequencer
//   freezes until the register frees up; no row is lost or repeated.
//   aresetn (synchronous, active low) returns the sequencer to idle and drops
//   m_valid; stack contents are not cleared (each pop reads a pushed entry).
module circle_quadrant_row_widths_top #(
    parameter int MAX_RADIUS = cqrw_pkg::MAX_RADIUS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cqrw_pkg::RADIUS_W-1:0] s_radius,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cqrw_pkg::ROW_W-1:0]    m_row_width,
    output logic                          m_last_row
);

    import cqrw_pkg::*;

    // Stack depth covers every push: x decrements fewer than radius times.
    localparam int AW  = $clog2(MAX_RADIUS + 1);
    localparam int CW  = AW + 1;
    localparam int YW  = RADIUS_W + 1;
    localparam logic [RADIUS_W-1:0] MAX_R = RADIUS_W'(MAX_RADIUS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,  // waiting for a radius
        ST_SCAN = 4'b0010,  // one midpoint pass per cycle while the output register is free
        ST_PREP = 4'b0100,  // prime the registered stack read
        ST_POP  = 4'b1000   // one pop per cycle while the output register is free
    } state_t;

    state_t                     state_reg, state_next;
    logic [RADIUS_W-1:0]        x_reg, x_next;
    logic [YW-1:0]              y_reg, y_next;
    logic [DEC_W-1:0]           dec_reg, dec_next;   // two's complement
    logic [CW-1:0]              cnt_reg, cnt_next;

    logic                       m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]           m_row_width_reg, m_row_width_next;
    logic                       m_last_row_reg, m_last_row_next;

    // stack port
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [ROW_W-1:0]           wr_data;
    logic [AW-1:0]              rd_addr;
    logic [ROW_W-1:0]           rd_data;

    // datapath helpers
    logic                       out_free;
    logic                       load;
    logic [RADIUS_W-1:0]        r_sat;
    logic [YW-1:0]              y_inc;
    logic [RADIUS_W-1:0]        x_dec;
    logic                       dec_pos;
    logic [DEC_W-1:0]           addend;
    logic                       scan_done;

    cqrw_stack #(
        .AW (AW),
        .DW (ROW_W)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign r_sat    = (s_radius > MAX_R) ? MAX_R : s_radius;
    assign y_inc    = y_reg + YW'(1);
    assign x_dec    = x_reg - RADIUS_W'(1);
    assign dec_pos  = !dec_reg[DEC_W-1] && (dec_reg != '0);
    // Shared adder operand: 2y+1, less 2x when x steps in.
    assign addend   = DEC_W'({y_inc, 1'b1})
                    - (dec_pos ? DEC_W'({x_dec, 1'b0}) : DEC_W'(0));
    // Read the entry just below the next top; the registered read returns it in the following cycle.
    assign rd_addr  = cnt_next[AW-1:0] - AW'(1);

    always_comb begin
        state_next       = state_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        dec_next         = dec_reg;
        cnt_next         = cnt_reg;
        load             = 1'b0;
        m_row_width_next = m_row_width_reg;
        m_last_row_next  = m_last_row_reg;
        wr_en            = 1'b0;
        wr_addr          = cnt_reg[AW-1:0];
        wr_data          = y_inc[ROW_W-1:0];
        scan_done        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next   = r_sat;
                    y_next   = '0;
                    dec_next = DEC_W'(1) - DEC_W'(r_sat);
                    cnt_next = '0;
                    if (r_sat != '0) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    load             = 1'b1;
                    m_row_width_next = x_reg;
                    y_next           = y_inc;
                    dec_next         = dec_reg + addend;
                    if (dec_pos) begin
                        x_next   = x_dec;
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    scan_done       = !({1'b0, x_next} > y_next);
                    m_last_row_next = scan_done && (cnt_next == '0);
                    if (scan_done) begin
                        state_next = (cnt_next != '0) ? ST_PREP : ST_IDLE;
                    end
                end
            end
            ST_PREP: begin
                state_next = ST_POP;
            end
            ST_POP: begin
                if (out_free) begin
                    load             = 1'b1;
                    m_row_width_next = rd_data;
                    m_last_row_next  = (cnt_reg == CW'(1));
                    cnt_next         = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            x_reg       <= '0;
            y_reg       <= '0;
            dec_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            dec_reg     <= dec_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge aclk) begin
        m_row_width_reg <= m_row_width_next;
        m_last_row_reg  <= m_last_row_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_row_width = m_row_width_reg;
    assign m_last_row  = m_last_row_reg;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for circle_quadrant_row_widths_top.
// Depends on cqrw_pkg and the block RTL; predicts every quadrant row of each radius
// and checks each output transaction against it.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cqrw_pkg::*;

    localparam int RADIUS_LIMIT   = MAX_RADIUS_DEFAULT;
    localparam int MAX_ROWS       = 64;     // rows one radius can ever produce
    localparam int RANDOM_RADII   = 190;
    localparam int MAX_GAP        = 8;      // longest idle/stall drawn per transaction
    localparam int HOLD_OFF_AT    = 200;    // row count that triggers the long hold-off
    localparam int HOLD_OFF_LEN   = 400;
    localparam int DRAIN_CYCLES   = 100;    // ~ worst-case radius latency plus margin
    localparam int WATCHDOG_LIMIT = 3000;   // quiet cycles; well above the hold-off

    // One expected output transaction.
    typedef struct packed {
        logic [ROW_W-1:0] width;
        logic             last;
    } quad_row_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [RADIUS_W-1:0] s_radius = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [ROW_W-1:0]    m_row_width;
    logic                m_last_row;

    logic [RADIUS_W-1:0] radii_pending[$];  // radii not yet offered to the block
    quad_row_t           rows_due[$];       // predicted rows, oldest first
    int                  radii_total  = 0;
    int                  radii_taken  = 0;
    int                  rows_seen    = 0;
    int                  n_errors     = 0;
    int                  feed_gap     = 0;
    int                  stall_left   = 0;
    int                  hold_left    = 0;
    bit                  hold_done    = 1'b0;
    int                  quiet_cycles = 0;

    circle_quadrant_row_widths_top #(
        .MAX_RADIUS (RADIUS_LIMIT)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_radius    (s_radius),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_width (m_row_width),
        .m_last_row  (m_last_row)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Midpoint scan for one radius. Rows from the scan come out in order; every
    // x step pushes the current y, and those come back out last-pushed-first
    // once the scan meets the diagonal. The final row carries the last flag.
    task automatic queue_rows(input logic [RADIUS_W-1:0] radius);
        logic [ROW_W-1:0]        x_cur;
        logic [6:0]              y_cur;
        logic signed [DEC_W-1:0] dec;
        logic [ROW_W-1:0]        steps[$];
        quad_row_t               rows[$];
        int                      r;
        r = int'(radius);
        if (r > RADIUS_LIMIT)
            r = RADIUS_LIMIT;
        x_cur = ROW_W'(r);
        y_cur = '0;
        dec   = DEC_W'(1 - r);
        while (x_cur > y_cur && rows.size() < MAX_ROWS) begin
            rows.insert(rows.size(), quad_row_t'{width: x_cur, last: 1'b0});
            y_cur++;
            if (dec <= 0) begin
                dec += DEC_W'(2 * int'(y_cur) + 1);
            end else begin
                x_cur--;
                dec += DEC_W'(2 * int'(y_cur) - 2 * int'(x_cur) + 1);
                steps.insert(steps.size(), y_cur[ROW_W-1:0]);
            end
        end
        while (steps.size() > 0 && rows.size() < MAX_ROWS)
            rows.insert(rows.size(), quad_row_t'{width: steps.pop_back(), last: 1'b0});
        // radius zero yields nothing at all
        if (rows.size() > 0)
            rows[rows.size() - 1].last = 1'b1;
        foreach (rows[i])
            rows_due.insert(rows_due.size(), rows[i]);
    endtask

    // Driver: one radius per transaction, a random idle gap before each offer.
    // A stretch of back-to-back offers keeps the input side saturated for a while.
    // s_valid gets exactly one NBA per edge so an immediate re-offer never glitches.
    always @(posedge aclk) begin
        logic offer;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_radius <= '0;
            feed_gap = $urandom_range(0, MAX_GAP);
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                queue_rows(s_radius);
                radii_taken++;
                offer = 1'b0;
                feed_gap = (radii_taken >= 100 && radii_taken < 140) ?
                           0 : $urandom_range(0, MAX_GAP);
            end
            if (!offer) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                end else if (radii_pending.size() > 0) begin
                    offer = 1'b1;
                    s_radius <= radii_pending.pop_front();
                end
            end
            s_valid <= offer;
        end
    end

    // Monitor and receiver: checks each row transaction against the oldest
    // prediction, then draws a stall before taking the next one. Once, after
    // HOLD_OFF_AT rows, m_ready drops for a long stretch so the block backs up
    // and holds s_ready low while the driver keeps offering.
    always @(posedge aclk) begin
        quad_row_t exp_row;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, MAX_GAP);
        end else begin
            if (m_valid && m_ready) begin
                rows_seen++;
                if (rows_due.size() == 0) begin
                    $display("%0t: unexpected row transaction: width %0d last %0b",
                             $time, m_row_width, m_last_row);
                    n_errors++;
                end else begin
                    exp_row = rows_due.pop_front();
                    if (m_row_width !== exp_row.width) begin
                        $display("%0t: row_width mismatch: expected %0d, actual %0d",
                                 $time, exp_row.width, m_row_width);
                        n_errors++;
                    end
                    if (m_last_row !== exp_row.last) begin
                        $display("%0t: last_row mismatch: expected %0b, actual %0b",
                                 $time, exp_row.last, m_last_row);
                        n_errors++;
                    end
                end
                stall_left = (rows_seen >= 1000 && rows_seen < 1600) ?
                             0 : $urandom_range(0, MAX_GAP);
            end
            if (!hold_done && rows_seen >= HOLD_OFF_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung block shows up as a long run of cycles with no
    // transaction on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [RADIUS_W-1:0] directed[$];
        logic [RADIUS_W-1:0] r;
        int                  sel;
        // Smallest and largest radius, radius zero (no rows, also back to back),
        // single-bit radii so each bit is set alone, and a few mid values.
        directed = {6'd1, 6'd63, 6'd0, 6'd0, 6'd2, 6'd3, 6'd4, 6'd5, 6'd7,
                    6'd8, 6'd16, 6'd31, 6'd32, 6'd42, 6'd21, 6'd62, 6'd0,
                    6'd10, 6'd1, 6'd63};
        foreach (directed[i])
            radii_pending.insert(radii_pending.size(), directed[i]);
        // Random radii lean toward small ones and the top of the range.
        repeat (RANDOM_RADII) begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
                r = '0;
            else if (sel < 30)
                r = RADIUS_W'($urandom_range(1, 8));
            else if (sel < 45)
                r = RADIUS_W'($urandom_range(56, 63));
            else
                r = RADIUS_W'($urandom_range(1, 63));
            radii_pending.insert(radii_pending.size(), r);
        end
        radii_total = radii_pending.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (radii_taken < radii_total)
            @(posedge aclk);
        while (rows_due.size() != 0)
            @(posedge aclk);
        // let any stray rows surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_errors == 0 && rows_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
